[sv/nsat_pkg.sv]
// ----------------------------------------------------------------------------
// nsat_pkg
// Shared widths, command codes and the compare unit result type for the
// aging address table.
// ----------------------------------------------------------------------------
`default_nettype none

package nsat_pkg;

	localparam int ADDR_W      = 32;
	localparam int VMS_W       = 26;
	localparam int TIME_W      = 32;
	localparam int CNT_W       = 5;
	localparam int CMD_W       = 2;
	localparam int ENTRY_W     = ADDR_W + TIME_W;
	localparam int DEF_ENTRIES = 16;

	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	// result of the shared add / subtract unit
	typedef struct packed {
		logic              zero;
		logic              neg;
		logic [TIME_W-1:0] sum;
	} alu_res_t;

endpackage

`default_nettype wire

[sv/nsat_ram.sv]
// ----------------------------------------------------------------------------
// nsat_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[sv/nsat_alu.sv]
// ----------------------------------------------------------------------------
// nsat_alu
// Shared 32-bit add / subtract unit: address match, expiry test and the
// new expiry sum all go through it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsat_alu (
	input  wire logic [nsat_pkg::TIME_W-1:0] a,
	input  wire logic [nsat_pkg::TIME_W-1:0] b,
	input  wire logic                        sub,
	output nsat_pkg::alu_res_t               res
);

	logic [nsat_pkg::TIME_W-1:0] b_x;

	always_comb begin
		b_x      = b ^ {nsat_pkg::TIME_W{sub}};
		res.sum  = a + b_x + nsat_pkg::TIME_W'(sub);
		res.zero = (res.sum == '0);
		res.neg  = res.sum[nsat_pkg::TIME_W-1];
	end

endmodule

`default_nettype wire

[sv/neighbor_selector_aging_table.sv]
// ----------------------------------------------------------------------------
// neighbor_selector_aging_table
// Table of IPv4 addresses with millisecond expiry times.
//
// Input channel (in_valid / in_stall) carries one word: command, address and
// validity_ms. Update refreshes or inserts an address, lookup reports its
// presence, tick advances the millisecond clock and drops expired entries.
// Output channel (out_valid / out_stall) returns one word per input word.
// Each word walks the whole table through one RAM read port and one shared
// compare unit: a scan state reads every entry, a drain state takes the last
// read data and a finish state registers the result. The block goes back to
// idle before it takes the next word, so it cannot take a new word before
// the result of the last one is registered.
// in_stall is high while a word is being worked on. If the receiver stalls
// and the previous result is still held, the finish step waits, so nothing
// is lost or overwritten.
// Reset clears all valid bits, the clock and the entry count; address and
// expiry storage is only used for valid entries and needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_selector_aging_table #(
	parameter int ENTRIES = nsat_pkg::DEF_ENTRIES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [nsat_pkg::CMD_W-1:0]   command,
	input  wire logic [nsat_pkg::ADDR_W-1:0]  address,
	input  wire logic [nsat_pkg::VMS_W-1:0]   validity_ms,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              found,
	output logic                              added,
	output logic                              table_full,
	output logic      [nsat_pkg::CNT_W-1:0]   removed_count,
	output logic      [nsat_pkg::CNT_W-1:0]   entry_count,
	output logic                              changed
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]                     state_q;
	logic [nsat_pkg::CMD_W-1:0]     cmd_q;
	logic [nsat_pkg::ADDR_W-1:0]    addr_q;
	logic [nsat_pkg::VMS_W-1:0]     vms_q;
	logic [nsat_pkg::TIME_W-1:0]    now_q;
	logic [CW-1:0]                  valid_count_q;
	logic [CW-1:0]                  rm_cnt_q;
	logic [ENTRIES-1:0]             valid_q;
	logic [IW-1:0]                  rd_idx_q;
	logic                           cv_s1;
	logic [IW-1:0]                  ci_s1;
	logic                           hit_q;
	logic [IW-1:0]                  hit_idx_q;
	logic                           free_q;
	logic [IW-1:0]                  free_idx_q;

	logic                           in_acc;
	logic                           rd_en;
	logic [nsat_pkg::ENTRY_W-1:0]   rd_data;
	logic                           wr_en;
	logic [IW-1:0]                  wr_addr;
	logic [nsat_pkg::ENTRY_W-1:0]   wr_data;
	logic [nsat_pkg::TIME_W-1:0]    alu_a;
	logic [nsat_pkg::TIME_W-1:0]    alu_b;
	logic                           alu_sub;
	nsat_pkg::alu_res_t             alu_res;
	logic                           is_upd;
	logic                           is_look;
	logic                           is_tick;
	logic                           ent_v;
	logic                           fin_go;
	logic                           do_ins;
	logic [CW-1:0]                  new_count;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign is_upd   = (cmd_q == nsat_pkg::CMD_UPDATE);
	assign is_look  = (cmd_q == nsat_pkg::CMD_LOOKUP);
	assign is_tick  = (cmd_q == nsat_pkg::CMD_TICK);
	assign ent_v    = valid_q[ci_s1];
	assign rd_en    = (state_q == ST_SCAN);
	assign fin_go   = (state_q == ST_FIN) && (!out_valid || !out_stall);
	assign do_ins   = is_upd && !hit_q && free_q;
	assign new_count = valid_count_q + CW'(do_ins);

	// shared unit: entry compare while scanning, new expiry sum at finish
	always_comb begin
		alu_a   = now_q;
		alu_b   = nsat_pkg::TIME_W'(vms_q);
		alu_sub = 1'b0;
		if (state_q != ST_FIN) begin
			alu_sub = 1'b1;
			if (is_tick) begin
				alu_a = rd_data[nsat_pkg::TIME_W-1:0];
				alu_b = now_q;
			end else begin
				alu_a = rd_data[nsat_pkg::ENTRY_W-1:nsat_pkg::TIME_W];
				alu_b = addr_q;
			end
		end
	end

	nsat_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	// hit rewrites expiry only; the address stored is the same
	assign wr_en   = fin_go && is_upd && (hit_q || free_q);
	assign wr_addr = hit_q ? hit_idx_q : free_idx_q;
	assign wr_data = {addr_q, alu_res.sum};

	nsat_ram #(
		.WIDTH (nsat_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			cv_s1    <= 1'b0;
			ci_s1    <= '0;
		end else begin
			cv_s1 <= rd_en;
			ci_s1 <= rd_idx_q;
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (in_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input word hold
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= command;
			addr_q <= address;
			vms_q  <= validity_ms;
		end
	end

	// table state and scan results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			valid_count_q <= '0;
			valid_q       <= '0;
			rm_cnt_q      <= '0;
			hit_q         <= 1'b0;
			hit_idx_q     <= '0;
			free_q        <= 1'b0;
			free_idx_q    <= '0;
		end else begin
			if (in_acc) begin
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
				rm_cnt_q <= '0;
				if (command == nsat_pkg::CMD_TICK) begin
					now_q <= now_q + 1'b1;
				end
			end
			if (cv_s1) begin
				if (is_tick) begin
					if (ent_v && alu_res.neg) begin
						valid_q[ci_s1] <= 1'b0;
						valid_count_q  <= valid_count_q - 1'b1;
						rm_cnt_q       <= rm_cnt_q + 1'b1;
					end
				end else if (is_upd || is_look) begin
					// first matching slot and first free slot
					if (ent_v && alu_res.zero && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= ci_s1;
					end
					if (!ent_v && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= ci_s1;
					end
				end
			end
			if (fin_go && do_ins) begin
				valid_q[free_idx_q] <= 1'b1;
				valid_count_q       <= new_count;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fin_go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			found         <= hit_q;
			added         <= do_ins;
			table_full    <= is_upd && !hit_q && !free_q;
			removed_count <= nsat_pkg::CNT_W'(rm_cnt_q);
			entry_count   <= nsat_pkg::CNT_W'(new_count);
			changed       <= do_ins || (rm_cnt_q != '0);
		end
	end

endmodule

`default_nettype wire

[test/tb_neighbor_selector_aging_table.sv]
// ----------------------------------------------------------------------------
// tb_neighbor_selector_aging_table
// Self-checking bench for the aging address table. A short directed table
// covers reset state, refresh on hit, expiry, a full table and the unused
// command. About 700 random words follow, drawn from a small address pool so
// that hits, inserts, drops and expiries all occur. Results are checked field
// by field against a directed row's values, if set, or the table model, while
// the sender idles in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_neighbor_selector_aging_table;

	localparam int ADDR_W       = nsat_pkg::ADDR_W;
	localparam int VMS_W        = nsat_pkg::VMS_W;
	localparam int TIME_W       = nsat_pkg::TIME_W;
	localparam int CNT_W        = nsat_pkg::CNT_W;
	localparam int CMD_W        = nsat_pkg::CMD_W;
	localparam int ENTRIES      = nsat_pkg::DEF_ENTRIES;
	localparam int RANDOM_WORDS = 700;
	localparam int POOL_SIZE    = 24;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = ENTRIES + 12;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [VMS_W-1:0] VMS_MAX    = 26'd65535000;

	// field order: found, added, table_full, removed_count, entry_count, changed
	typedef struct packed {
		logic             found;
		logic             added;
		logic             table_full;
		logic [CNT_W-1:0] removed_count;
		logic [CNT_W-1:0] entry_count;
		logic             changed;
	} result_t;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic [VMS_W-1:0]  vms;
		bit                typed;
		result_t           want;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;
	logic [VMS_W-1:0]  validity_ms;
	logic              out_valid;
	logic              out_stall;
	logic              found;
	logic              added;
	logic              table_full;
	logic [CNT_W-1:0]  removed_count;
	logic [CNT_W-1:0]  entry_count;
	logic              changed;

	// table model
	bit                tbl_valid [ENTRIES];
	logic [ADDR_W-1:0] tbl_addr [ENTRIES];
	logic [TIME_W-1:0] tbl_expiry [ENTRIES];
	logic [TIME_W-1:0] clock_ms = '0;
	int                live_count = 0;

	result_t           expected_results [$];
	result_t           oldest_result;
	stim_row_t         directed_rows [$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	int errors      = 0;
	int words_seen  = 0;
	int cycle_count = 0;
	int stall_phase = 0;
	int stall_mode  = 0;

	neighbor_selector_aging_table #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.address(address),
		.validity_ms(validity_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.added(added),
		.table_full(table_full),
		.removed_count(removed_count),
		.entry_count(entry_count),
		.changed(changed)
	);

	always #6 clk = ~clk;

	function automatic result_t predict_table(input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] addr, input logic [VMS_W-1:0] vms);
		result_t           r;
		int                hit;
		int                slot;
		logic [TIME_W-1:0] left;
		r = '0;
		hit = -1;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && tbl_valid[i] && tbl_addr[i] == addr)
				hit = i;
		if (cmd == nsat_pkg::CMD_UPDATE) begin
			if (hit >= 0) begin
				r.found = 1'b1;
				tbl_expiry[hit] = clock_ms + TIME_W'(vms);
			end else begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !tbl_valid[i])
						slot = i;
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b1;
					tbl_addr[slot] = addr;
					tbl_expiry[slot] = clock_ms + TIME_W'(vms);
					live_count++;
					r.added = 1'b1;
					r.changed = 1'b1;
				end else begin
					r.table_full = 1'b1;
				end
			end
		end else if (cmd == nsat_pkg::CMD_LOOKUP) begin
			r.found = (hit >= 0);
		end else if (cmd == nsat_pkg::CMD_TICK) begin
			clock_ms = clock_ms + 1'b1;
			for (int i = 0; i < ENTRIES; i++) begin
				// expired when expiry lies before now in serial order
				left = tbl_expiry[i] - clock_ms;
				if (tbl_valid[i] && left[TIME_W-1]) begin
					tbl_valid[i] = 1'b0;
					live_count--;
					r.removed_count = r.removed_count + 1'b1;
				end
			end
			r.changed = (r.removed_count != 0);
		end
		r.entry_count = live_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic [VMS_W-1:0] vms, input bit typed, input result_t want);
		stim_row_t row;
		row.cmd = cmd;
		row.addr = addr;
		row.vms = vms;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic [VMS_W-1:0] vms, input bit typed, input result_t want);
		result_t r;
		command <= cmd;
		address <= addr;
		validity_ms <= vms;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		r = predict_table(cmd, addr, vms);
		expected_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// receiver stall pattern in one of four randomly chosen modes
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_phase = $urandom_range(20, 80);
		end else begin
			stall_phase = stall_phase - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_phase[2];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
			end else begin
				oldest_result = expected_results.pop_front();
				if (found !== oldest_result.found)
					report_mismatch($sformatf("word %0d found: expected %0d got %0d",
						words_seen, oldest_result.found, found));
				if (added !== oldest_result.added)
					report_mismatch($sformatf("word %0d added: expected %0d got %0d",
						words_seen, oldest_result.added, added));
				if (table_full !== oldest_result.table_full)
					report_mismatch($sformatf("word %0d table_full: expected %0d got %0d",
						words_seen, oldest_result.table_full, table_full));
				if (removed_count !== oldest_result.removed_count)
					report_mismatch($sformatf("word %0d removed_count: expected %0d got %0d",
						words_seen, oldest_result.removed_count, removed_count));
				if (entry_count !== oldest_result.entry_count)
					report_mismatch($sformatf("word %0d entry_count: expected %0d got %0d",
						words_seen, oldest_result.entry_count, entry_count));
				if (changed !== oldest_result.changed)
					report_mismatch($sformatf("word %0d changed: expected %0d got %0d",
						words_seen, oldest_result.changed, changed));
			end
			words_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int               burst;
		int               gap;
		int               sent;
		int               pick;
		logic [CMD_W-1:0]  rc;
		logic [ADDR_W-1:0] ra;
		logic [VMS_W-1:0]  rv;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = nsat_pkg::CMD_LOOKUP;
		address = '0;
		validity_ms = '0;
		for (int i = 0; i < ENTRIES; i++)
			tbl_valid[i] = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;

		// empty table after reset, unused command, refresh on hit
		add_row(nsat_pkg::CMD_LOOKUP, 32'h0000_0000, '0, 1,
			'{1'b0, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0});
		add_row(nsat_pkg::CMD_TICK, 32'h0000_0000, '0, 1,
			'{1'b0, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0});
		add_row(CMD_UNUSED, 32'hFFFF_FFFF, VMS_MAX, 1,
			'{1'b0, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0});
		add_row(nsat_pkg::CMD_UPDATE, 32'hFFFF_FFFF, '0, 1,
			'{1'b0, 1'b1, 1'b0, 5'd0, 5'd1, 1'b1});
		add_row(nsat_pkg::CMD_UPDATE, 32'hFFFF_FFFF, VMS_MAX, 1,
			'{1'b1, 1'b0, 1'b0, 5'd0, 5'd1, 1'b0});
		add_row(nsat_pkg::CMD_UPDATE, 32'h0000_0000, '0, 1,
			'{1'b0, 1'b1, 1'b0, 5'd0, 5'd2, 1'b1});
		add_row(nsat_pkg::CMD_LOOKUP, 32'h0000_0000, '0, 1,
			'{1'b1, 1'b0, 1'b0, 5'd0, 5'd2, 1'b0});
		// zero validity entry expires on the next tick, the refreshed one stays
		add_row(nsat_pkg::CMD_TICK, 32'h0000_0000, '0, 1,
			'{1'b0, 1'b0, 1'b0, 5'd1, 5'd1, 1'b1});
		add_row(nsat_pkg::CMD_LOOKUP, 32'h0000_0000, '0, 1,
			'{1'b0, 1'b0, 1'b0, 5'd0, 5'd1, 1'b0});
		// fill the table, then one insert too many
		for (int i = 1; i < ENTRIES; i++)
			add_row(nsat_pkg::CMD_UPDATE, 32'h0A00_0000 + i, '0, 0, '0);
		add_row(nsat_pkg::CMD_UPDATE, 32'hC0A8_0001, 26'd1, 1,
			'{1'b0, 1'b0, 1'b1, 5'd0, 5'd16, 1'b0});
		add_row(nsat_pkg::CMD_TICK, 32'h0000_0000, '0, 1,
			'{1'b0, 1'b0, 1'b0, 5'd15, 5'd1, 1'b1});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].vms,
				directed_rows[i].typed, directed_rows[i].want);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < RANDOM_WORDS; b++) begin
				pick = $urandom_range(0, 99);
				rc = (pick < 40) ? nsat_pkg::CMD_UPDATE :
					(pick < 65) ? nsat_pkg::CMD_LOOKUP :
					(pick < 95) ? nsat_pkg::CMD_TICK : CMD_UNUSED;
				// mostly a small pool so hits and a full table are common
				ra = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
					: $urandom;
				pick = $urandom_range(0, 99);
				rv = (pick < 70) ? VMS_W'($urandom_range(0, 40)) :
					(pick < 95) ? VMS_W'($urandom_range(0, 400)) :
					VMS_W'($urandom_range(0, VMS_MAX));
				send_word(rc, ra, rv, 0, '0);
				sent++;
			end
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && expected_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
